// File: sv/anem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anem_pkg
// shared types, register map, reset values and scaling helper for the
// analog nub event mapper
// ----------------------------------------------------------------------------
package anem_pkg;

  localparam int unsigned FracShift  = 8;
  localparam int unsigned AbsShift   = 3;
  localparam int unsigned UpPulseA   = 5;
  localparam int unsigned UpPulseB   = 6;
  localparam int unsigned UpStageMax = 7;
  localparam int unsigned StableMax  = 255;
  localparam int unsigned AddrW      = 5;

  typedef enum logic [1:0] {
    ModeAbs     = 2'd0,
    ModeMouse   = 2'd1,
    ModeScroll  = 2'd2,
    ModeButtons = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KindAbs     = 2'd0,
    KindMotion  = 2'd1,
    KindWheel   = 2'd2,
    KindButtons = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    DirCenter = 3'd0,
    DirUp     = 3'd1,
    DirRight  = 3'd2,
    DirDown   = 3'd3,
    DirLeft   = 3'd4
  } dir_e;

  typedef enum logic [2:0] {
    RegEventMode  = 3'd0,
    RegMouseGain  = 3'd1,
    RegScrollXGn  = 3'd2,
    RegScrollYGn  = 3'd3,
    RegScrollDiv  = 3'd4,
    RegThreshX    = 3'd5,
    RegThreshY    = 3'd6,
    RegHoldDelay  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    mode_e       event_mode;
    logic [15:0] mouse_gain;
    logic [15:0] scroll_x_gain;
    logic [15:0] scroll_y_gain;
    logic [5:0]  scroll_divider;
    logic [5:0]  button_threshold_x;
    logic [5:0]  button_threshold_y;
    logic [7:0]  hold_delay;
  } anem_cfg_t;

  localparam anem_cfg_t CfgReset = '{
    event_mode:         ModeAbs,
    mouse_gain:         16'd435,
    scroll_x_gain:      16'd20,
    scroll_y_gain:      16'd20,
    scroll_divider:     6'd13,
    button_threshold_x: 6'd20,
    button_threshold_y: 6'd26,
    hold_delay:         8'd1
  };

  // signed 8.8 gain scaling, quotient truncated toward zero
  function automatic logic signed [15:0] scale_gain(logic signed [8:0] v,
                                                    logic signed [15:0] g);
    logic signed [24:0] p;
    logic signed [24:0] adj;
    p   = 25'(v) * 25'(g);
    adj = p + (p[24] ? 25'sd255 : 25'sd0);
    return adj[FracShift +: 16];
  endfunction

endpackage

// File: sv/anem_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anem_if
// valid/ready channels for joystick samples and mapped events
// ----------------------------------------------------------------------------
interface anem_in_if;
  logic              valid;
  logic              ready;
  logic              sample_present;
  logic signed [7:0] rel_x;
  logic signed [7:0] rel_y;
  logic signed [7:0] abs_x;
  logic signed [7:0] abs_y;

  modport source (output valid, sample_present, rel_x, rel_y, abs_x, abs_y,
                  input ready);
  modport sink (input valid, sample_present, rel_x, rel_y, abs_x, abs_y,
                output ready);
endinterface

interface anem_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic signed [15:0] value_x;
  logic signed [15:0] value_y;
  logic               left_pressed;
  logic               middle_pressed;
  logic               right_pressed;

  modport source (output valid, event_kind, value_x, value_y, left_pressed,
                  middle_pressed, right_pressed, input ready);
  modport sink (input valid, event_kind, value_x, value_y, left_pressed,
                middle_pressed, right_pressed, output ready);
endinterface

// File: sv/anem_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anem_cfg_regs
// apb register file holding mode, gains, scroll pacing and button settings
// ----------------------------------------------------------------------------
module anem_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output anem_pkg::anem_cfg_t  cfg_o
);
  import anem_pkg::*;

  anem_cfg_t cfg_q, cfg_d;
  reg_idx_e  idx;
  logic      wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegEventMode: cfg_d.event_mode         = mode_e'(pwdata[1:0]);
        RegMouseGain: cfg_d.mouse_gain         = pwdata[15:0];
        RegScrollXGn: cfg_d.scroll_x_gain      = pwdata[15:0];
        RegScrollYGn: cfg_d.scroll_y_gain      = pwdata[15:0];
        RegScrollDiv: cfg_d.scroll_divider     = pwdata[5:0];
        RegThreshX:   cfg_d.button_threshold_x = pwdata[5:0];
        RegThreshY:   cfg_d.button_threshold_y = pwdata[5:0];
        RegHoldDelay: cfg_d.hold_delay         = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegEventMode: prdata = {30'd0, cfg_q.event_mode};
      RegMouseGain: prdata = {16'd0, cfg_q.mouse_gain};
      RegScrollXGn: prdata = {16'd0, cfg_q.scroll_x_gain};
      RegScrollYGn: prdata = {16'd0, cfg_q.scroll_y_gain};
      RegScrollDiv: prdata = {26'd0, cfg_q.scroll_divider};
      RegThreshX:   prdata = {26'd0, cfg_q.button_threshold_x};
      RegThreshY:   prdata = {26'd0, cfg_q.button_threshold_y};
      RegHoldDelay: prdata = {24'd0, cfg_q.hold_delay};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: sv/anem_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anem_mapper
// sample register, per-mode event mapping and result register
// ----------------------------------------------------------------------------
module anem_mapper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  anem_pkg::anem_cfg_t cfg_i,
  anem_in_if.sink             in_i,
  anem_out_if.source          out_o
);
  import anem_pkg::*;

  // sample stage
  logic              s1_valid_q, s1_valid_d;
  logic              s1_present_q;
  logic signed [7:0] s1_rx_q, s1_ry_q, s1_ax_q, s1_ay_q;
  logic              s1_adv;
  logic              in_take;

  // result stage
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_kind_q, out_kind_d;
  logic signed [15:0] out_x_q, out_x_d;
  logic signed [15:0] out_y_q, out_y_d;
  logic [2:0]         out_btn_q, out_btn_d;

  // mapping state
  logic [5:0] scroll_cnt_q, scroll_cnt_d;
  dir_e       prev_dir_q, prev_dir_d;
  logic [7:0] stable_q, stable_d;
  dir_e       active_dir_q, active_dir_d;
  logic [2:0] up_stage_q, up_stage_d;

  // datapath
  logic signed [7:0]  rx, ry, ax, ay;
  logic signed [8:0]  mul_x_v, mul_y_v;
  logic signed [15:0] mul_x_g, mul_y_g;
  logic signed [15:0] scaled_x, scaled_y;
  logic signed [9:0]  ax10, ay10, tx10, ty10;
  logic [5:0]         scroll_inc;
  dir_e               dir_raw, dir_eff;
  logic               emit;

  assign s1_adv    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take   = in_i.valid && in_i.ready;
  assign s1_valid_d = in_take || (s1_valid_q && !s1_adv);

  assign rx = s1_present_q ? s1_rx_q : 8'sd0;
  assign ry = s1_present_q ? s1_ry_q : 8'sd0;
  assign ax = s1_present_q ? s1_ax_q : 8'sd0;
  assign ay = s1_present_q ? s1_ay_q : 8'sd0;

  always_comb begin
    if (cfg_i.event_mode == ModeMouse) begin
      mul_x_v = 9'(rx);
      mul_y_v = -9'(ry);
      mul_x_g = $signed(cfg_i.mouse_gain);
      mul_y_g = $signed(cfg_i.mouse_gain);
    end else begin
      mul_x_v = 9'(ax);
      mul_y_v = 9'(ay);
      mul_x_g = $signed(cfg_i.scroll_x_gain);
      mul_y_g = $signed(cfg_i.scroll_y_gain);
    end
  end

  assign scaled_x = scale_gain(mul_x_v, mul_x_g);
  assign scaled_y = scale_gain(mul_y_v, mul_y_g);

  assign ax10 = 10'(ax);
  assign ay10 = 10'(ay);
  assign tx10 = $signed({4'd0, cfg_i.button_threshold_x});
  assign ty10 = $signed({4'd0, cfg_i.button_threshold_y});

  always_comb begin
    if (ax10 >= tx10) begin
      dir_raw = DirRight;
    end else if (ax10 <= -tx10) begin
      dir_raw = DirLeft;
    end else if (ay10 >= ty10) begin
      dir_raw = DirUp;
    end else if (ay10 <= -ty10) begin
      dir_raw = DirDown;
    end else begin
      dir_raw = DirCenter;
    end
  end

  assign scroll_inc = scroll_cnt_q + 6'd1;

  always_comb begin
    scroll_cnt_d = scroll_cnt_q;
    prev_dir_d   = prev_dir_q;
    stable_d     = stable_q;
    active_dir_d = active_dir_q;
    up_stage_d   = up_stage_q;
    emit         = 1'b1;
    out_kind_d   = KindAbs;
    out_x_d      = 16'sd0;
    out_y_d      = 16'sd0;
    out_btn_d    = 3'd0;
    dir_eff      = dir_raw;

    case (cfg_i.event_mode)
      ModeMouse: begin
        out_kind_d = KindMotion;
        out_x_d    = scaled_x;
        out_y_d    = scaled_y;
      end
      ModeScroll: begin
        out_kind_d = KindWheel;
        out_x_d    = scaled_x;
        out_y_d    = scaled_y;
        if (scroll_inc < cfg_i.scroll_divider) begin
          scroll_cnt_d = scroll_inc;
          emit         = 1'b0;
        end else begin
          scroll_cnt_d = 6'd0;
        end
      end
      ModeButtons: begin
        out_kind_d = KindButtons;
        if (!s1_present_q) begin
          active_dir_d = DirCenter;
        end else begin
          if (dir_raw != prev_dir_q) begin
            prev_dir_d = dir_raw;
            stable_d   = 8'd0;
          end else if (stable_q < 8'(StableMax)) begin
            stable_d = stable_q + 8'd1;
          end
          if (stable_d < cfg_i.hold_delay) begin
            dir_eff = active_dir_q;
          end
          if (dir_eff != DirUp) begin
            up_stage_d = 3'd0;
          end else if (up_stage_q < 3'(UpStageMax)) begin
            up_stage_d = up_stage_q + 3'd1;
          end
          case (dir_eff)
            DirUp: begin
              out_btn_d[0] = (up_stage_d == 3'd1) || (up_stage_d == 3'd2) ||
                             (up_stage_d == 3'(UpPulseA)) ||
                             (up_stage_d == 3'(UpPulseB));
            end
            DirRight: out_btn_d = 3'b100;
            DirDown:  out_btn_d = 3'b010;
            DirLeft:  out_btn_d = 3'b001;
            default:  out_btn_d = 3'b000;
          endcase
          active_dir_d = dir_eff;
        end
      end
      default: begin
        out_kind_d = KindAbs;
        out_x_d    = 16'(ax) <<< AbsShift;
        out_y_d    = -(16'(ay) <<< AbsShift);
      end
    endcase
  end

  assign out_valid_d = s1_adv ? emit : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      scroll_cnt_q <= 6'd0;
      prev_dir_q   <= DirCenter;
      stable_q     <= 8'd0;
      active_dir_q <= DirCenter;
      up_stage_q   <= 3'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        scroll_cnt_q <= scroll_cnt_d;
        prev_dir_q   <= prev_dir_d;
        stable_q     <= stable_d;
        active_dir_q <= active_dir_d;
        up_stage_q   <= up_stage_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_present_q <= in_i.sample_present;
      s1_rx_q      <= in_i.rel_x;
      s1_ry_q      <= in_i.rel_y;
      s1_ax_q      <= in_i.abs_x;
      s1_ay_q      <= in_i.abs_y;
    end
    if (s1_adv && emit) begin
      out_kind_q <= out_kind_d;
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
      out_btn_q  <= out_btn_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.event_kind     = out_kind_q;
  assign out_o.value_x        = out_x_q;
  assign out_o.value_y        = out_y_q;
  assign out_o.left_pressed   = out_btn_q[0];
  assign out_o.middle_pressed = out_btn_q[1];
  assign out_o.right_pressed  = out_btn_q[2];

endmodule

// File: sv/analog_nub_event_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_nub_event_mapper_top
// maps polled joystick samples to position, motion, wheel or button events
// a sample is held in the sample register, then its result in the result register
// throughput: one sample per cycle while the receiver is ready, set by the sample and result registers
// scroll mode gives a result only on every scroll_divider-th sample
// reset clears the mapping state and loads the default register values
// ----------------------------------------------------------------------------
module analog_nub_event_mapper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  anem_in_if.sink     in_i,
  anem_out_if.source  out_o
);
  import anem_pkg::*;

  anem_cfg_t cfg;

  anem_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  anem_mapper u_mapper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

// File: sim/anem_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anem_event_checker
// watches the register port and both channels of the event mapper, keeps its
// own copy of the registers and mapping state, predicts the event for every
// accepted sample, if it gives one, and compares each delivered event field by field in order
// ----------------------------------------------------------------------------
module anem_event_checker
  import anem_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  input  logic [31:0]      prdata,
  input  logic             pready,
  anem_in_if               smp_mon,
  anem_out_if              evt_mon,
  output int               errors_o,
  output int               pending_o,
  output int               samples_o,
  output int               events_o,
  output int               writes_o
);

  localparam int FracOne  = 256;
  localparam int AbsScale = 8;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               left;
    logic               middle;
    logic               right;
  } evt_t;

  anem_cfg_t  cfg;
  logic [5:0] scroll_cnt;
  dir_e       last_dir;
  logic [7:0] stable_cnt;
  dir_e       applied_dir;
  logic [2:0] up_stage;
  evt_t       expected_events[$];

  // signed 8.8 gain, quotient truncated toward zero
  function automatic int scaled(int v, logic [15:0] g);
    int gs;
    gs = int'($signed(g));
    return (v * gs) / FracOne;
  endfunction

  function automatic bit map_sample(input logic present,
                                    input logic signed [7:0] rx8, ry8, ax8, ay8,
                                    output evt_t ev);
    int         rx, ry, ax, ay;
    dir_e       dir;
    logic [2:0] btn;
    rx  = 0;
    ry  = 0;
    ax  = 0;
    ay  = 0;
    ev  = '0;
    btn = '0;
    if (present) begin
      rx = rx8;
      ry = ry8;
      ax = ax8;
      ay = ay8;
    end
    case (cfg.event_mode)
      ModeMouse: begin
        ev.kind = KindMotion;
        ev.vx   = 16'(scaled(rx, cfg.mouse_gain));
        ev.vy   = 16'(scaled(-ry, cfg.mouse_gain));
        return 1'b1;
      end
      ModeScroll: begin
        scroll_cnt = scroll_cnt + 6'd1;
        if (scroll_cnt < cfg.scroll_divider) return 1'b0;
        scroll_cnt = '0;
        ev.kind = KindWheel;
        ev.vx   = 16'(scaled(ax, cfg.scroll_x_gain));
        ev.vy   = 16'(scaled(ay, cfg.scroll_y_gain));
        return 1'b1;
      end
      ModeButtons: begin
        ev.kind = KindButtons;
        // missing sample releases everything, history kept
        if (!present) begin
          applied_dir = DirCenter;
          return 1'b1;
        end
        dir = DirCenter;
        if (ax >= int'(cfg.button_threshold_x)) dir = DirRight;
        else if (ax <= -int'(cfg.button_threshold_x)) dir = DirLeft;
        else if (ay >= int'(cfg.button_threshold_y)) dir = DirUp;
        else if (ay <= -int'(cfg.button_threshold_y)) dir = DirDown;
        if (dir != last_dir) begin
          last_dir   = dir;
          stable_cnt = '0;
        end else if (stable_cnt < StableMax) begin
          stable_cnt++;
        end
        if (stable_cnt < cfg.hold_delay) dir = applied_dir;
        if (dir != DirUp) up_stage = '0;
        case (dir)
          DirUp: begin
            if (up_stage < UpStageMax) up_stage++;
            btn[0] = (up_stage == 3'd1) || (up_stage == 3'd2) ||
                     (up_stage == UpPulseA) || (up_stage == UpPulseB);
          end
          DirRight: btn = 3'b100;
          DirDown:  btn = 3'b010;
          DirLeft:  btn = 3'b001;
          default:  btn = 3'b000;
        endcase
        applied_dir = dir;
        {ev.right, ev.middle, ev.left} = btn;
        return 1'b1;
      end
      default: begin
        ev.kind = KindAbs;
        ev.vx   = 16'(ax * AbsScale);
        ev.vy   = 16'(-ay * AbsScale);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void write_reg(input logic [2:0] idx, input logic [31:0] d);
    case (reg_idx_e'(idx))
      RegEventMode: cfg.event_mode         = mode_e'(d[1:0]);
      RegMouseGain: cfg.mouse_gain         = d[15:0];
      RegScrollXGn: cfg.scroll_x_gain      = d[15:0];
      RegScrollYGn: cfg.scroll_y_gain      = d[15:0];
      RegScrollDiv: cfg.scroll_divider     = d[5:0];
      RegThreshX:   cfg.button_threshold_x = d[5:0];
      RegThreshY:   cfg.button_threshold_y = d[5:0];
      RegHoldDelay: cfg.hold_delay         = d[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx,
                                            output logic [31:0] mask);
    mask = 32'h0000_003f;
    case (reg_idx_e'(idx))
      RegEventMode: begin
        mask = 32'h0000_0003;
        return 32'(cfg.event_mode);
      end
      RegMouseGain: begin
        mask = 32'h0000_ffff;
        return 32'(cfg.mouse_gain);
      end
      RegScrollXGn: begin
        mask = 32'h0000_ffff;
        return 32'(cfg.scroll_x_gain);
      end
      RegScrollYGn: begin
        mask = 32'h0000_ffff;
        return 32'(cfg.scroll_y_gain);
      end
      RegScrollDiv: return 32'(cfg.scroll_divider);
      RegThreshX:   return 32'(cfg.button_threshold_x);
      RegThreshY:   return 32'(cfg.button_threshold_y);
      RegHoldDelay: begin
        mask = 32'h0000_00ff;
        return 32'(cfg.hold_delay);
      end
      default: return '0;
    endcase
  endfunction

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (want !== got) begin
      errors_o++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    evt_t        ev;
    evt_t        want;
    logic [31:0] mask;
    logic [31:0] val;
    if (!rst_ni) begin
      cfg         = CfgReset;
      scroll_cnt  = '0;
      last_dir    = DirCenter;
      stable_cnt  = '0;
      applied_dir = DirCenter;
      up_stage    = '0;
      expected_events.delete();
      errors_o    = 0;
      pending_o   = 0;
      samples_o   = 0;
      events_o    = 0;
      writes_o    = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          write_reg(paddr[AddrW-1:2], pwdata);
          writes_o++;
        end else begin
          val = reg_value(paddr[AddrW-1:2], mask);
          check_field("register read", val, prdata & mask);
        end
      end
      if (smp_mon.valid && smp_mon.ready) begin
        samples_o++;
        if (map_sample(smp_mon.sample_present, smp_mon.rel_x, smp_mon.rel_y,
                       smp_mon.abs_x, smp_mon.abs_y, ev))
          expected_events.push_back(ev);
      end
      if (evt_mon.valid && evt_mon.ready) begin
        events_o++;
        if (expected_events.size() == 0) begin
          errors_o++;
          $display("%0t ns: event with none expected, expected nothing, actual kind %0d",
                   $time, evt_mon.event_kind);
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", want.kind, evt_mon.event_kind);
          check_field("value_x", want.vx, evt_mon.value_x);
          check_field("value_y", want.vy, evt_mon.value_y);
          check_field("left_pressed", want.left, evt_mon.left_pressed);
          check_field("middle_pressed", want.middle, evt_mon.middle_pressed);
          check_field("right_pressed", want.right, evt_mon.right_pressed);
        end
      end
      pending_o = expected_events.size();
    end
  end

endmodule

// File: sim/analog_nub_event_mapper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_nub_event_mapper_top_tb
// drives joystick samples and register writes into the event mapper under
// random sender and receiver stalls; a checker beside the block predicts and
// compares every event, this module only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module analog_nub_event_mapper_top_tb;
  import anem_pkg::*;

  typedef struct packed {
    logic              present;
    logic signed [7:0] rx;
    logic signed [7:0] ry;
    logic signed [7:0] ax;
    logic signed [7:0] ay;
  } smp_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;
  int cur_hold;
  int cur_thx;
  int cur_thy;
  int errors;
  int pending;
  int samples;
  int events;
  int writes;

  anem_in_if  smp_if ();
  anem_out_if evt_if ();

  analog_nub_event_mapper_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (smp_if),
    .out_o   (evt_if)
  );

  anem_event_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .smp_mon   (smp_if),
    .evt_mon   (evt_if),
    .errors_o  (errors),
    .pending_o (pending),
    .samples_o (samples),
    .events_o  (events),
    .writes_o  (writes)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver stalls, with one long hold-off on request
  initial begin
    evt_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        evt_if.ready <= 1'b0;
        repeat (80) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        evt_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic smp_t mk_smp(logic p, int rx, int ry, int ax, int ay);
    smp_t s;
    s.present = p;
    s.rx      = 8'(rx);
    s.ry      = 8'(ry);
    s.ax      = 8'(ax);
    s.ay      = 8'(ay);
    return s;
  endfunction

  function automatic int rand_byte();
    case ($urandom_range(7))
      0:       return ($urandom_range(1) != 0) ? 127 : -128;
      1:       return ($urandom_range(1) != 0) ? 0 : -1;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic smp_t random_smp();
    return mk_smp($urandom_range(9) != 0, rand_byte(), rand_byte(), rand_byte(),
                  rand_byte());
  endfunction

  // magnitude at or past a threshold, often right on it
  function automatic int span(int lo, int hi);
    if (lo >= hi) return hi;
    if ($urandom_range(1) != 0) return lo;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int inner(int t);
    int m;
    if (t <= 0) return 0;
    m = $urandom_range(t - 1);
    return ($urandom_range(1) != 0) ? m : -m;
  endfunction

  function automatic smp_t aimed_smp(int d);
    int ax;
    int ay;
    case (d)
      DirRight: begin
        ax = span(cur_thx, 127);
        ay = rand_byte();
      end
      DirLeft: begin
        ax = -span(cur_thx, 128);
        ay = rand_byte();
      end
      DirUp: begin
        ax = inner(cur_thx);
        ay = span(cur_thy, 127);
      end
      DirDown: begin
        ax = inner(cur_thx);
        ay = -span(cur_thy, 128);
      end
      default: begin
        ax = inner(cur_thx);
        ay = inner(cur_thy);
      end
    endcase
    return mk_smp(1'b1, rand_byte(), rand_byte(), ax, ay);
  endfunction

  // sample requests wait out random sender gaps
  task automatic send_smp(smp_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid          <= 1'b1;
    smp_if.sample_present <= s.present;
    smp_if.rel_x          <= s.rx;
    smp_if.rel_y          <= s.ry;
    smp_if.abs_x          <= s.ax;
    smp_if.abs_y          <= s.ay;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    smp_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // junk above the field width must be dropped by the block
  task automatic reg_write(reg_idx_e idx, int value, int width);
    logic [31:0] d;
    d = ($urandom() << width) | (32'(value) & ((32'd1 << width) - 32'd1));
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic reg_read(reg_idx_e idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic program_config(mode_e m, int mg, int sxg, int syg, int div, int thx,
                                int thy, int hold);
    drain();
    reg_write(RegEventMode, m, 2);
    reg_write(RegMouseGain, mg, 16);
    reg_write(RegScrollXGn, sxg, 16);
    reg_write(RegScrollYGn, syg, 16);
    reg_write(RegScrollDiv, div, 6);
    reg_write(RegThreshX, thx, 6);
    reg_write(RegThreshY, thy, 6);
    reg_write(RegHoldDelay, hold, 8);
    for (int i = 0; i < 8; i++) reg_read(reg_idx_e'(i));
    cur_hold = hold;
    cur_thx  = thx;
    cur_thy  = thy;
  endtask

  task automatic send_burst(int n);
    for (int i = 0; i < n; i++) send_smp(random_smp());
  endtask

  // runs of one direction, some longer than the hold delay, with noise
  task automatic button_runs(int n);
    int   sent;
    int   len;
    int   d;
    int   r;
    smp_t s;
    sent = 0;
    while (sent < n) begin
      d   = $urandom_range(4);
      len = ($urandom_range(3) == 0) ? cur_hold + $urandom_range(6, 1) : $urandom_range(8, 1);
      for (int k = 0; k < len && sent < n; k++) begin
        r = $urandom_range(19);
        s = (r == 0) ? random_smp() : aimed_smp(d);
        if (r == 1) s.present = 1'b0;
        send_smp(s);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    smp_if.valid          = 1'b0;
    smp_if.sample_present = 1'b0;
    smp_if.rel_x          = '0;
    smp_if.rel_y          = '0;
    smp_if.abs_x          = '0;
    smp_if.abs_y          = '0;
    send_idle_pct         = 27;
    recv_idle_pct         = 49;
    hold_off_req          = 1'b0;
    cur_hold              = 1;
    cur_thx               = 20;
    cur_thy               = 26;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // absolute mode from reset values
    send_smp(mk_smp(1'b1, 5, -5, 127, -128));
    send_smp(mk_smp(1'b1, -7, 9, -128, 127));
    send_smp(mk_smp(1'b0, 55, -3, 99, -99));

    program_config(ModeMouse, 435, 20, 20, 13, 20, 26, 1);
    send_smp(mk_smp(1'b1, 127, -128, 0, 0));
    send_smp(mk_smp(1'b1, -128, 127, 0, 0));
    send_smp(mk_smp(1'b1, -1, 1, 3, 3));

    // wheel: divider dropped below the count, then zero
    program_config(ModeScroll, 435, 32767, -32768, 13, 20, 26, 1);
    for (int i = 0; i < 5; i++)
      send_smp(mk_smp(1'b1, 0, 0, i[0] ? 127 : -128, i[0] ? -128 : 127));
    drain();
    reg_write(RegScrollDiv, 2, 6);
    send_smp(mk_smp(1'b1, 1, 1, -128, -128));
    drain();
    reg_write(RegScrollDiv, 0, 6);
    send_smp(mk_smp(1'b0, 1, 1, 100, 100));

    // held up pulses across a missing sample
    program_config(ModeButtons, 435, 20, 20, 13, 20, 26, 1);
    for (int i = 0; i < 4; i++) send_smp(mk_smp(1'b1, 0, 0, 0, 127));
    send_smp(mk_smp(1'b0, 0, 0, 0, 127));
    for (int i = 0; i < 5; i++) send_smp(mk_smp(1'b1, 0, 0, 0, 127));

    program_config(ModeAbs, $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(65535), 13, 20, 26, 1);
    send_burst(150);
    program_config(ModeMouse, $urandom_range(65535), 20, 20, 13, 20, 26, 1);
    send_burst(150);
    program_config(ModeScroll, 435, $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(8, 1), 20, 26, 1);
    send_burst(160);
    program_config(ModeButtons, 435, 20, 20, 13, $urandom_range(32, 1),
                   $urandom_range(32, 1), $urandom_range(3));
    button_runs(150);

    drain();
    send_idle_pct = 49;
    recv_idle_pct = 27;
    program_config(ModeMouse, -32768, 20, 20, 13, 20, 26, 1);
    send_burst(100);
    program_config(ModeScroll, 435, 32767, -32768, 40, 20, 26, 1);
    send_burst(200);
    program_config(ModeButtons, 435, 20, 20, 13, 1, 32, 255);
    button_runs(350);
    program_config(ModeAbs, 435, 20, 20, 13, 20, 26, 1);
    send_burst(80);

    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_config(ModeMouse, 32767, 20, 20, 13, 20, 26, 1);
    hold_off_req = 1'b1;
    send_burst(100);
    program_config(ModeScroll, 435, $urandom_range(65535), $urandom_range(65535), 0,
                   20, 26, 1);
    send_burst(100);
    program_config(ModeButtons, 435, 20, 20, 13, 0, 63, 1);
    button_runs(150);
    program_config(ModeScroll, 435, $urandom_range(65535), $urandom_range(65535), 1,
                   20, 26, 1);
    send_burst(100);
    drain();

    $display("run covered %0d samples, %0d events and %0d register writes in all four modes",
             samples, events, writes);
    $display("with sender and receiver stalls, a long output hold-off, wheel pacing and held directions");
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
